@@ hw/rtl/egp_pkg.sv @@
package egp_pkg;

  // width of each coordinate field on the ports
  localparam int unsigned FIELD_W = 32;
  // default coordinate width in use
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // four turn tests and three lifted rows per request
  localparam int unsigned NUM_TURNS = 4;
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_COMPS = 4 * NUM_TURNS + 2 * NUM_ROWS;

  // component slots inside one turn test (vector a against vector b)
  localparam int unsigned CMP_AX = 0;
  localparam int unsigned CMP_AY = 1;
  localparam int unsigned CMP_BX = 2;
  localparam int unsigned CMP_BY = 3;
  // first slot of the lifted rows (x then y per row)
  localparam int unsigned ROW_BASE = 4 * NUM_TURNS;

  typedef enum logic [1:0] {
    MODE_TURN   = 2'd0,
    MODE_TRI    = 2'd1,
    MODE_CONVEX = 2'd2,
    MODE_CIRCLE = 2'd3
  } mode_e;

  // verdict codes, two's complement
  localparam logic signed [1:0] VERDICT_POS  = 2'sb01;
  localparam logic signed [1:0] VERDICT_ZERO = 2'sb00;
  localparam logic signed [1:0] VERDICT_NEG  = 2'sb11;

  // width of a coordinate after field extraction
  function automatic int unsigned coord_w(input int unsigned cw);
    return (cw > FIELD_W) ? FIELD_W + 1 : cw;
  endfunction

  // width of one queue entry: mode plus all difference components
  function automatic int unsigned entry_w(input int unsigned cw);
    return 2 + NUM_COMPS * (coord_w(cw) + 1);
  endfunction

endpackage

@@ hw/rtl/egp_mul.sv @@
module egp_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33,
  parameter int unsigned K  = 34
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned NA = (AW + K - 1) / K;
  localparam int unsigned NB = (BW + K - 1) / K;
  localparam int unsigned PW = (NA + NB) * K;

  logic signed [NA*K-1:0]  a_ext;
  logic signed [NB*K-1:0]  b_ext;
  logic signed [K:0]       ca [NA];
  logic signed [K:0]       cb [NB];
  logic signed [2*K+1:0]   part_q [NA][NB];
  logic signed [PW-1:0]    acc;
  logic signed [AW+BW-1:0] p_q;

  assign a_ext = (NA*K)'(a_i);
  assign b_ext = (NB*K)'(b_i);

  // split operands: low chunks unsigned, top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ca[i] = (i == NA - 1) ? {a_ext[i*K+K-1], a_ext[i*K +: K]} : {1'b0, a_ext[i*K +: K]};
    end
    for (int j = 0; j < NB; j++) begin
      cb[j] = (j == NB - 1) ? {b_ext[j*K+K-1], b_ext[j*K +: K]} : {1'b0, b_ext[j*K +: K]};
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          part_q[i][j] <= ca[i] * cb[j];
        end
      end
    end
  end

  // weighted sum of the partials
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(part_q[i][j]) <<< ((i + j) * K));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

@@ hw/rtl/egp_front.sv @@
module egp_front import egp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic [1:0]                         mode_i,
  input  logic signed [FIELD_W-1:0]          point0_x_i,
  input  logic signed [FIELD_W-1:0]          point0_y_i,
  input  logic signed [FIELD_W-1:0]          point1_x_i,
  input  logic signed [FIELD_W-1:0]          point1_y_i,
  input  logic signed [FIELD_W-1:0]          point2_x_i,
  input  logic signed [FIELD_W-1:0]          point2_y_i,
  input  logic signed [FIELD_W-1:0]          point3_x_i,
  input  logic signed [FIELD_W-1:0]          point3_y_i,
  output logic [entry_w(COORD_WIDTH)-1:0]    entry_o
);

  localparam int unsigned EW = coord_w(COORD_WIDTH);
  localparam int unsigned DW = EW + 1;

  logic signed [EW-1:0] px [4];
  logic signed [EW-1:0] py [4];
  logic signed [DW-1:0] dx [4][4];
  logic signed [DW-1:0] dy [4][4];
  logic signed [DW-1:0] comp [NUM_COMPS];

  // field extraction: low bits taken as signed, wide settings read unsigned
  always_comb begin
    px[0] = EW'({1'b0, point0_x_i});
    py[0] = EW'({1'b0, point0_y_i});
    px[1] = EW'({1'b0, point1_x_i});
    py[1] = EW'({1'b0, point1_y_i});
    px[2] = EW'({1'b0, point2_x_i});
    py[2] = EW'({1'b0, point2_y_i});
    px[3] = EW'({1'b0, point3_x_i});
    py[3] = EW'({1'b0, point3_y_i});
  end

  // all pairwise differences, exact at one extra bit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        dx[i][j] = DW'(px[i]) - DW'(px[j]);
        dy[i][j] = DW'(py[i]) - DW'(py[j]);
      end
    end
  end

  // pick the turn tests for the mode, rows are always relative to p3
  always_comb begin
    for (int k = 0; k < NUM_COMPS; k++) begin
      comp[k] = '0;
    end
    unique case (mode_e'(mode_i))
      MODE_TURN: begin
        comp[CMP_AX] = DW'(px[0]);
        comp[CMP_AY] = DW'(py[0]);
        comp[CMP_BX] = DW'(px[1]);
        comp[CMP_BY] = DW'(py[1]);
      end
      MODE_TRI: begin
        comp[CMP_AX]     = dx[3][0];
        comp[CMP_AY]     = dy[3][0];
        comp[CMP_BX]     = dx[1][0];
        comp[CMP_BY]     = dy[1][0];
        comp[4 + CMP_AX] = dx[3][1];
        comp[4 + CMP_AY] = dy[3][1];
        comp[4 + CMP_BX] = dx[2][1];
        comp[4 + CMP_BY] = dy[2][1];
        comp[8 + CMP_AX] = dx[3][2];
        comp[8 + CMP_AY] = dy[3][2];
        comp[8 + CMP_BX] = dx[0][2];
        comp[8 + CMP_BY] = dy[0][2];
      end
      MODE_CONVEX: begin
        comp[CMP_AX]      = dx[2][0];
        comp[CMP_AY]      = dy[2][0];
        comp[CMP_BX]      = dx[1][0];
        comp[CMP_BY]      = dy[1][0];
        comp[4 + CMP_AX]  = dx[3][0];
        comp[4 + CMP_AY]  = dy[3][0];
        comp[4 + CMP_BX]  = dx[1][0];
        comp[4 + CMP_BY]  = dy[1][0];
        comp[8 + CMP_AX]  = dx[0][2];
        comp[8 + CMP_AY]  = dy[0][2];
        comp[8 + CMP_BX]  = dx[3][2];
        comp[8 + CMP_BY]  = dy[3][2];
        comp[12 + CMP_AX] = dx[1][2];
        comp[12 + CMP_AY] = dy[1][2];
        comp[12 + CMP_BX] = dx[3][2];
        comp[12 + CMP_BY] = dy[3][2];
      end
      MODE_CIRCLE: begin
        comp[CMP_AX] = dx[2][0];
        comp[CMP_AY] = dy[2][0];
        comp[CMP_BX] = dx[1][0];
        comp[CMP_BY] = dy[1][0];
      end
      default: begin
      end
    endcase
    for (int r = 0; r < NUM_ROWS; r++) begin
      comp[ROW_BASE + 2*r]     = dx[r][3];
      comp[ROW_BASE + 2*r + 1] = dy[r][3];
    end
  end

  // pack into one queue entry
  always_comb begin
    entry_o[1:0] = mode_i;
    for (int k = 0; k < NUM_COMPS; k++) begin
      entry_o[2 + k*DW +: DW] = comp[k];
    end
  end

endmodule

@@ hw/rtl/egp_queue.sv @@
module egp_queue import egp_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

@@ hw/rtl/egp_back.sv @@
module egp_back import egp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [entry_w(COORD_WIDTH)-1:0]  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [1:0]                verdict_o
);

  localparam int unsigned EW   = coord_w(COORD_WIDTH);
  localparam int unsigned DW   = EW + 1;
  localparam int unsigned XW   = 2 * DW + 1;
  localparam int unsigned ZW   = 2 * DW + 1;
  localparam int unsigned M1W  = DW + ZW + 1;
  localparam int unsigned FW   = DW + M1W;
  localparam int unsigned DETW = FW + 2;
  localparam int unsigned K    = DW + 1;
  localparam int unsigned NST  = 10;

  logic                    en;
  logic [NST-1:0]          vld_q;
  logic signed [DW-1:0]    comp [NUM_COMPS];
  mode_e                   mode_q [NST-1];

  // turn products and squares (two stages)
  logic signed [2*DW-1:0]  pp [NUM_TURNS];
  logic signed [2*DW-1:0]  qq [NUM_TURNS];
  logic signed [2*DW-1:0]  sqx [NUM_ROWS];
  logic signed [2*DW-1:0]  sqy [NUM_ROWS];
  logic signed [XW-1:0]    xprod [NUM_TURNS];
  logic signed [1:0]       ts_d [NUM_TURNS];
  logic signed [1:0]       ts_q [7][NUM_TURNS];

  // rows carried to the lift stage
  logic signed [DW-1:0]    rx_q [3][NUM_ROWS];
  logic signed [DW-1:0]    ry_q [3][NUM_ROWS];
  logic signed [ZW-1:0]    z_q [NUM_ROWS];

  // minors of the lifted determinant
  logic signed [DW+ZW-1:0] by_cz, bz_cy, bz_cx, bx_cz;
  logic signed [2*DW-1:0]  bx_cy, by_cx;
  logic signed [M1W-1:0]   m1_q, m2_q;
  logic signed [ZW-1:0]    m3_q;
  logic signed [DW-1:0]    ax_q [3];
  logic signed [DW-1:0]    ay_q [3];
  logic signed [ZW-1:0]    az_q [3];

  // final cofactor products and determinant
  logic signed [FW-1:0]    f1, f2;
  logic signed [2*ZW-1:0]  f3;
  logic signed [DETW-1:0]  det_q;
  logic signed [1:0]       det_s;
  logic signed [1:0]       lo, hi;
  logic signed [1:0]       verdict_d, verdict_q;
  logic                    any_zero, odd_neg;

  // whole pipe moves unless the result register is held
  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];
  assign verdict_o   = verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // unpack the queue entry
  always_comb begin
    for (int k = 0; k < NUM_COMPS; k++) begin
      comp[k] = in_data_i[2 + k*DW +: DW];
    end
  end

  // turn cross products and row squares
  for (genvar t = 0; t < NUM_TURNS; t++) begin : g_turn
    egp_mul #(.AW(DW), .BW(DW), .K(K)) u_mul_p (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (comp[4*t + CMP_AX]),
      .b_i   (comp[4*t + CMP_BY]),
      .p_o   (pp[t])
    );
    egp_mul #(.AW(DW), .BW(DW), .K(K)) u_mul_q (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (comp[4*t + CMP_AY]),
      .b_i   (comp[4*t + CMP_BX]),
      .p_o   (qq[t])
    );
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    egp_mul #(.AW(DW), .BW(DW), .K(K)) u_mul_x (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (comp[ROW_BASE + 2*r]),
      .b_i   (comp[ROW_BASE + 2*r]),
      .p_o   (sqx[r])
    );
    egp_mul #(.AW(DW), .BW(DW), .K(K)) u_mul_y (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (comp[ROW_BASE + 2*r + 1]),
      .b_i   (comp[ROW_BASE + 2*r + 1]),
      .p_o   (sqy[r])
    );
  end

  // turn sign is the negated sign of the cross product
  always_comb begin
    for (int t = 0; t < NUM_TURNS; t++) begin
      xprod[t] = XW'(pp[t]) - XW'(qq[t]);
      if (xprod[t][XW-1]) begin
        ts_d[t] = VERDICT_POS;
      end else if (xprod[t] != '0) begin
        ts_d[t] = VERDICT_NEG;
      end else begin
        ts_d[t] = VERDICT_ZERO;
      end
    end
  end

  // payload delay lines and stage registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q[0] <= mode_e'(in_data_i[1:0]);
      for (int s = 1; s < NST - 1; s++) begin
        mode_q[s] <= mode_q[s-1];
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
        rx_q[0][r] <= comp[ROW_BASE + 2*r];
        ry_q[0][r] <= comp[ROW_BASE + 2*r + 1];
        for (int s = 1; s < 3; s++) begin
          rx_q[s][r] <= rx_q[s-1][r];
          ry_q[s][r] <= ry_q[s-1][r];
        end
        z_q[r] <= ZW'(sqx[r]) + ZW'(sqy[r]);
      end
      for (int t = 0; t < NUM_TURNS; t++) begin
        ts_q[0][t] <= ts_d[t];
        for (int s = 1; s < 7; s++) begin
          ts_q[s][t] <= ts_q[s-1][t];
        end
      end
      ax_q[0] <= rx_q[2][0];
      ay_q[0] <= ry_q[2][0];
      az_q[0] <= z_q[0];
      for (int s = 1; s < 3; s++) begin
        ax_q[s] <= ax_q[s-1];
        ay_q[s] <= ay_q[s-1];
        az_q[s] <= az_q[s-1];
      end
      m1_q  <= M1W'(by_cz) - M1W'(bz_cy);
      m2_q  <= M1W'(bz_cx) - M1W'(bx_cz);
      m3_q  <= ZW'(bx_cy) - ZW'(by_cx);
      det_q <= DETW'(f1) + DETW'(f2) + DETW'(f3);
      verdict_q <= verdict_d;
    end
  end

  // 2x2 minors of rows b and c
  egp_mul #(.AW(DW), .BW(ZW), .K(K)) u_by_cz (
    .clk_i (clk_i), .en_i (en), .a_i (ry_q[2][1]), .b_i (z_q[2]), .p_o (by_cz)
  );
  egp_mul #(.AW(DW), .BW(ZW), .K(K)) u_bz_cy (
    .clk_i (clk_i), .en_i (en), .a_i (ry_q[2][2]), .b_i (z_q[1]), .p_o (bz_cy)
  );
  egp_mul #(.AW(DW), .BW(ZW), .K(K)) u_bz_cx (
    .clk_i (clk_i), .en_i (en), .a_i (rx_q[2][2]), .b_i (z_q[1]), .p_o (bz_cx)
  );
  egp_mul #(.AW(DW), .BW(ZW), .K(K)) u_bx_cz (
    .clk_i (clk_i), .en_i (en), .a_i (rx_q[2][1]), .b_i (z_q[2]), .p_o (bx_cz)
  );
  egp_mul #(.AW(DW), .BW(DW), .K(K)) u_bx_cy (
    .clk_i (clk_i), .en_i (en), .a_i (rx_q[2][1]), .b_i (ry_q[2][2]), .p_o (bx_cy)
  );
  egp_mul #(.AW(DW), .BW(DW), .K(K)) u_by_cx (
    .clk_i (clk_i), .en_i (en), .a_i (ry_q[2][1]), .b_i (rx_q[2][2]), .p_o (by_cx)
  );

  // cofactor expansion along row a
  egp_mul #(.AW(DW), .BW(M1W), .K(K)) u_f1 (
    .clk_i (clk_i), .en_i (en), .a_i (ax_q[2]), .b_i (m1_q), .p_o (f1)
  );
  egp_mul #(.AW(DW), .BW(M1W), .K(K)) u_f2 (
    .clk_i (clk_i), .en_i (en), .a_i (ay_q[2]), .b_i (m2_q), .p_o (f2)
  );
  egp_mul #(.AW(ZW), .BW(ZW), .K(K)) u_f3 (
    .clk_i (clk_i), .en_i (en), .a_i (az_q[2]), .b_i (m3_q), .p_o (f3)
  );

  // verdict per mode
  always_comb begin
    if (det_q[DETW-1]) begin
      det_s = VERDICT_NEG;
    end else if (det_q != '0) begin
      det_s = VERDICT_POS;
    end else begin
      det_s = VERDICT_ZERO;
    end

    lo = ts_q[6][0];
    hi = ts_q[6][0];
    for (int t = 1; t < 3; t++) begin
      if (ts_q[6][t] < lo) begin
        lo = ts_q[6][t];
      end
      if (ts_q[6][t] > hi) begin
        hi = ts_q[6][t];
      end
    end

    any_zero = 1'b0;
    odd_neg  = 1'b0;
    for (int t = 0; t < NUM_TURNS; t++) begin
      if (ts_q[6][t] == VERDICT_ZERO) begin
        any_zero = 1'b1;
      end
      if (ts_q[6][t] == VERDICT_NEG) begin
        odd_neg = !odd_neg;
      end
    end

    unique case (mode_q[NST-2])
      MODE_TURN: begin
        verdict_d = ts_q[6][0];
      end
      MODE_TRI: begin
        if (lo == -hi) begin
          verdict_d = VERDICT_NEG;
        end else if (lo != VERDICT_ZERO) begin
          verdict_d = VERDICT_POS;
        end else begin
          verdict_d = VERDICT_ZERO;
        end
      end
      MODE_CONVEX: begin
        if (any_zero) begin
          verdict_d = VERDICT_ZERO;
        end else if (odd_neg) begin
          verdict_d = VERDICT_NEG;
        end else begin
          verdict_d = VERDICT_POS;
        end
      end
      MODE_CIRCLE: begin
        // clockwise triangle flips the determinant sign
        verdict_d = (ts_q[6][0] == VERDICT_POS) ? det_s : -det_s;
      end
      default: begin
        verdict_d = VERDICT_ZERO;
      end
    endcase
  end

endmodule

@@ hw/rtl/exact_geometric_predicate_unit_top.sv @@
// Exact 2D geometric predicates on integer points.
// Request channel: in_valid_i / in_ready_o with mode_i and four points
// point0..point3 (x, y, 32-bit two's complement). Mode selects turn sign,
// point in triangle, convex position or point in circumcircle.
// Result channel: out_valid_o / out_ready_i with verdict_o in {-1, 0, 1}.
// All arithmetic is carried at exact width, so no result can overflow.
// Throughput: one request per cycle while the receiver does not stall.
// The pipe follows the multiplier chain of the lifted 3x3 determinant
// (squares, minors, cofactors, each a two-stage multiply) and registers
// the verdict at its end.
// A two-entry queue sits between the classify front and the arithmetic
// pipe. When a result waits and out_ready_i is low the pipe holds, the
// queue fills, then in_ready_o drops; no request is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties the queue and the pipe.
module exact_geometric_predicate_unit_top import egp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic signed [FIELD_W-1:0] point0_x_i,
  input  logic signed [FIELD_W-1:0] point0_y_i,
  input  logic signed [FIELD_W-1:0] point1_x_i,
  input  logic signed [FIELD_W-1:0] point1_y_i,
  input  logic signed [FIELD_W-1:0] point2_x_i,
  input  logic signed [FIELD_W-1:0] point2_y_i,
  input  logic signed [FIELD_W-1:0] point3_x_i,
  input  logic signed [FIELD_W-1:0] point3_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [1:0]         verdict_o
);

  localparam int unsigned EntryW = entry_w(COORD_WIDTH);

  logic [EntryW-1:0] front_entry;
  logic [EntryW-1:0] back_entry;
  logic              back_valid;
  logic              back_ready;

  // classify and form differences
  egp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .mode_i     (mode_i),
    .point0_x_i (point0_x_i),
    .point0_y_i (point0_y_i),
    .point1_x_i (point1_x_i),
    .point1_y_i (point1_y_i),
    .point2_x_i (point2_x_i),
    .point2_y_i (point2_y_i),
    .point3_x_i (point3_x_i),
    .point3_y_i (point3_y_i),
    .entry_o    (front_entry)
  );

  // decoupling queue
  egp_queue #(.W(EntryW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (front_entry),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_data_o  (back_entry)
  );

  // arithmetic pipe and result register
  egp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (back_valid),
    .in_ready_o  (back_ready),
    .in_data_i   (back_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o)
  );

endmodule
